// ===== rtl/core/mandelbrot_escape_time_core_macros.svh =====
// Assertion macros shared by the escape-time core.
`ifndef MANDELBROT_ESCAPE_TIME_CORE_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_CORE_MACROS_SVH

// Checked at every clock edge outside reset.
`define MET_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked at every clock edge, reset included.
`define MET_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

// ===== rtl/core/met_pkg.sv =====
package met_pkg;

  localparam int FRAC_BITS = 28;

  localparam int COORD_W = 32;
  localparam int COUNT_W = 16;
  localparam int GRAY_W  = 8;

  // Operand width holds any value in [-2, 2]; product width holds exact squares.
  localparam int MUL_W  = FRAC_BITS + 3;
  localparam int PROD_W = 2 * MUL_W;
  // The iterate stays within +/-12 in the default format; the input itself needs 32 bits.
  localparam int Z_W    = (FRAC_BITS + 6 > COORD_W + 1) ? FRAC_BITS + 6 : COORD_W + 1;

  localparam int REM_W  = COUNT_W + GRAY_W;
  localparam int STEP_W = $clog2(GRAY_W);

  localparam logic [COUNT_W-1:0] MAX_ITER_RESET = COUNT_W'(1000);

  typedef struct packed {
    logic signed [COORD_W-1:0] point_real;
    logic signed [COORD_W-1:0] point_imag;
  } point_t;

  typedef struct packed {
    logic [COUNT_W-1:0] iteration_count;
    logic [GRAY_W-1:0]  gray_level;
  } result_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [COUNT_W-1:0] count;
  } iter_status_t;

  typedef struct packed {
    logic              busy;
    logic              valid;
    logic [GRAY_W-1:0] gray;
  } div_status_t;

endpackage

// ===== rtl/core/met_iter.sv =====
module met_iter (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  met_pkg::point_t        point_i,
  input  logic [met_pkg::COUNT_W-1:0] limit_i,
  output met_pkg::iter_status_t  status_o
);

  localparam int F   = met_pkg::FRAC_BITS;
  localparam int MW  = met_pkg::MUL_W;
  localparam int PW  = met_pkg::PROD_W;
  localparam int ZW  = met_pkg::Z_W;
  localparam int CW  = met_pkg::COUNT_W;

  localparam logic signed [ZW-1:0] TWO     = ZW'(1) << (F + 1);
  localparam logic signed [ZW-1:0] NEG_TWO = -TWO;
  localparam logic signed [PW-1:0] FOUR    = PW'(1) << (2 * F + 2);

  typedef enum logic [5:0] {
    IT_IDLE  = 6'b000001,
    IT_CHECK = 6'b000010,
    IT_SQX   = 6'b000100,
    IT_SQY   = 6'b001000,
    IT_XY    = 6'b010000,
    IT_UPD   = 6'b100000
  } iter_state_e;

  iter_state_e state_q, state_d;

  logic signed [ZW-1:0] x_q, y_q, cx_q, cy_q;
  logic signed [PW-1:0] xx_q, yy_q, xy_q, diff_q;
  logic [CW-1:0]        count_q;

  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] mag_sum;
  logic signed [ZW-1:0] next_x, next_y;
  logic                 out_of_range;
  logic                 at_limit;
  logic                 escaped;
  logic                 done;

  assign out_of_range = (x_q > TWO) || (x_q < NEG_TWO) || (y_q > TWO) || (y_q < NEG_TWO);
  assign at_limit     = count_q >= limit_i;

  always_comb begin
    unique case (state_q)
      IT_SQY: begin
        mul_a = $signed(y_q[MW-1:0]);
        mul_b = $signed(y_q[MW-1:0]);
      end
      IT_XY: begin
        mul_a = $signed(x_q[MW-1:0]);
        mul_b = $signed(y_q[MW-1:0]);
      end
      default: begin
        mul_a = $signed(x_q[MW-1:0]);
        mul_b = $signed(x_q[MW-1:0]);
      end
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign mag_sum = xx_q + yy_q;
  assign escaped = mag_sum > FOUR;
  assign next_x  = ZW'(diff_q >>> F) + cx_q;
  assign next_y  = ZW'(xy_q >>> (F - 1)) + cy_q;

  always_comb begin
    state_d = state_q;
    done    = 1'b0;
    unique case (state_q)
      IT_IDLE: begin
        if (start_i) begin
          state_d = IT_CHECK;
        end
      end
      IT_CHECK: begin
        if (at_limit || out_of_range) begin
          done    = 1'b1;
          state_d = IT_IDLE;
        end else begin
          state_d = IT_SQX;
        end
      end
      IT_SQX: state_d = IT_SQY;
      IT_SQY: state_d = IT_XY;
      IT_XY: begin
        if (escaped) begin
          done    = 1'b1;
          state_d = IT_IDLE;
        end else begin
          state_d = IT_UPD;
        end
      end
      IT_UPD:  state_d = IT_CHECK;
      default: state_d = IT_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IT_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == IT_IDLE && start_i) begin
      cx_q    <= ZW'(point_i.point_real);
      cy_q    <= ZW'(point_i.point_imag);
      x_q     <= ZW'(point_i.point_real);
      y_q     <= ZW'(point_i.point_imag);
      count_q <= '0;
    end
    if (state_q == IT_SQX) begin
      xx_q <= prod;
    end
    if (state_q == IT_SQY) begin
      yy_q <= prod;
    end
    if (state_q == IT_XY) begin
      xy_q   <= prod;
      diff_q <= xx_q - yy_q;
    end
    if (state_q == IT_UPD) begin
      x_q     <= next_x;
      y_q     <= next_y;
      count_q <= count_q + CW'(1);
    end
  end

  assign status_o.busy  = state_q != IT_IDLE;
  assign status_o.done  = done;
  assign status_o.count = count_q;

endmodule

// ===== rtl/core/met_div.sv =====
module met_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [met_pkg::COUNT_W-1:0] count_i,
  input  logic [met_pkg::COUNT_W-1:0] limit_i,
  input  logic                        ack_i,
  output met_pkg::div_status_t        status_o
);

  localparam int CW = met_pkg::COUNT_W;
  localparam int GW = met_pkg::GRAY_W;
  localparam int RW = met_pkg::REM_W;
  localparam int SW = met_pkg::STEP_W;

  typedef enum logic [2:0] {
    DV_IDLE = 3'b001,
    DV_RUN  = 3'b010,
    DV_HOLD = 3'b100
  } div_state_e;

  div_state_e state_q, state_d;

  logic [RW-1:0] rem_q;
  logic [GW-1:0] quot_q;
  logic [SW-1:0] step_q;

  logic [RW-1:0] div_sh;
  logic          fits;

  assign div_sh = RW'(limit_i) << step_q;
  assign fits   = rem_q >= div_sh;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      DV_IDLE: begin
        if (start_i) begin
          state_d = (limit_i == '0) ? DV_HOLD : DV_RUN;
        end
      end
      DV_RUN: begin
        if (step_q == '0) begin
          state_d = DV_HOLD;
        end
      end
      DV_HOLD: begin
        if (ack_i) begin
          state_d = DV_IDLE;
        end
      end
      default: state_d = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // The dividend is 255 times the count, formed as a shift and a subtract.
  always_ff @(posedge clk_i) begin
    if (state_q == DV_IDLE && start_i) begin
      rem_q  <= {count_i, {GW{1'b0}}} - RW'(count_i);
      quot_q <= '0;
      step_q <= SW'(GW - 1);
    end
    if (state_q == DV_RUN) begin
      if (fits) begin
        rem_q <= rem_q - div_sh;
      end
      quot_q <= {quot_q[GW-2:0], fits};
      step_q <= step_q - SW'(1);
    end
  end

  assign status_o.busy  = state_q != DV_IDLE;
  assign status_o.valid = state_q == DV_HOLD;
  assign status_o.gray  = quot_q;

endmodule

// ===== rtl/core/mandelbrot_escape_time_core.sv =====
// Each iteration of z passes through a range test, x*x, y*y, x*y and an update; the run
// ends on a final range test or a final magnitude test, then the gray level is divided
// out bit by bit and the result moves into the output register. When the limit is 0 the
// division is skipped. One multiplier forms x*x, y*y and x*y in turn, and a point is
// taken only after the previous result has moved to the output register, which an output
// stall can delay. Reset clears all control state and sets max_iterations to 1000.
`include "mandelbrot_escape_time_core_macros.svh"

module mandelbrot_escape_time_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [met_pkg::COUNT_W-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  met_pkg::point_t             in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output met_pkg::result_t            out_data_o
);

  logic [met_pkg::COUNT_W-1:0] max_iter_q;
  logic                        out_valid_q, out_valid_d;
  met_pkg::result_t            out_data_q;
  logic [met_pkg::COUNT_W-1:0] count_hold_q;

  met_pkg::iter_status_t iter_st;
  met_pkg::div_status_t  div_st;

  logic in_xfer;
  logic capture;

  assign in_stall_o = iter_st.busy || div_st.busy;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign capture    = div_st.valid && (!out_valid_q || !out_stall_i);

  met_iter u_iter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_xfer),
    .point_i  (in_data_i),
    .limit_i  (max_iter_q),
    .status_o (iter_st)
  );

  met_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (iter_st.done),
    .count_i  (iter_st.count),
    .limit_i  (max_iter_q),
    .ack_i    (capture),
    .status_o (div_st)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (capture) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q  <= met_pkg::MAX_ITER_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_iter_q <= cfg_wdata_i;
      end
      out_valid_q <= out_valid_d;
    end
  end

  // The count is held in count_hold_q until the result register takes it.
  always_ff @(posedge clk_i) begin
    if (capture) begin
      out_data_q.iteration_count <= count_hold_q;
      out_data_q.gray_level      <= div_st.gray;
    end
  end

  always_ff @(posedge clk_i) begin
    if (iter_st.done) begin
      count_hold_q <= iter_st.count;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `MET_ASSERT(a_units_exclusive, !(iter_st.busy && div_st.busy), "iteration and divide overlap")
  `MET_ASSERT(a_xfer_starts_iter, in_xfer |=> iter_st.busy, "accepted point did not start")
  `MET_ASSERT(a_count_in_limit, out_valid_o |-> (out_data_o.iteration_count <= max_iter_q), "count above limit")
  `MET_ASSERT_ALWAYS(a_reset_no_valid, !rst_ni |-> !out_valid_o, "result valid during reset")

endmodule
